// ===== hdl/xxhash64_stream_hasher_assert.svh =====
// Assertion macros for the checker file of the stream hasher.
// Depends on signals named clk and rst_n in the module that expands them.
`ifndef XXHASH64_STREAM_HASHER_ASSERT_SVH
`define XXHASH64_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define XXH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define XXH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/xxh64_pkg.sv =====
// Package for the XXH64 stream hasher: primes, rotate amounts, sequencer states.
// No dependencies; imported by the hasher top level.
package xxh64_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  // Lane start values for seed zero
  localparam logic [63:0] LANE0_INIT = P1 + P2;
  localparam logic [63:0] LANE1_INIT = P2;
  localparam logic [63:0] LANE2_INIT = 64'd0;
  localparam logic [63:0] LANE3_INIT = 64'd0 - P1;

  // Rotate and shift amounts
  localparam logic [5:0] ROT_ROUND = 6'd31;
  localparam logic [5:0] ROT_W64   = 6'd27;
  localparam logic [5:0] ROT_W32   = 6'd23;
  localparam logic [5:0] ROT_W8    = 6'd11;
  localparam logic [5:0] AVA_SH1   = 6'd33;
  localparam logic [5:0] AVA_SH2   = 6'd29;
  localparam logic [5:0] AVA_SH3   = 6'd32;

  // Word load lengths in bytes
  localparam logic [3:0] LD_W64 = 4'd8;
  localparam logic [3:0] LD_W32 = 4'd4;
  localparam logic [3:0] LD_W8  = 4'd1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LD, ST_MUL,
    ST_ABS_LD, ST_ABS_M1, ST_ABS_ADD, ST_ABS_WR,
    ST_FIN_START, ST_MRG_ADD, ST_MRG_M1, ST_MRG_M2, ST_MRG_X, ST_MRG_P4,
    ST_ADD_LEN, ST_TAIL,
    ST_T8_M1, ST_T8_M2, ST_T8_X, ST_T8_P4,
    ST_T4_M1, ST_T4_X, ST_T4_P3,
    ST_T1_M1, ST_T1_X, ST_T1_WR,
    ST_AVA0, ST_AVA1, ST_AVA2,
    ST_EMIT
  } st_t;

  // Constant operand of the shared multiplier
  typedef enum logic [1:0] {K_P1, K_P2, K_P3, K_P5} kc_t;

  function automatic logic [63:0] kconst(input kc_t k);
    logic [63:0] v;
    unique case (k)
      K_P1:    v = P1;
      K_P2:    v = P2;
      K_P3:    v = P3;
      K_P5:    v = P5;
      default: v = P1;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
    return (v << r) | (v >> (7'd64 - {1'b0, r}));
  endfunction

  function automatic logic [63:0] lane_init(input logic [1:0] i);
    logic [63:0] v;
    unique case (i)
      2'd0:    v = LANE0_INIT;
      2'd1:    v = LANE1_INIT;
      2'd2:    v = LANE2_INIT;
      default: v = LANE3_INIT;
    endcase
    return v;
  endfunction

  // Lane rotate used by the merge
  function automatic logic [63:0] merge_rot(input logic [63:0] v, input logic [1:0] i);
    logic [63:0] r;
    unique case (i)
      2'd0:    r = rotl64(v, 6'd1);
      2'd1:    r = rotl64(v, 6'd7);
      2'd2:    r = rotl64(v, 6'd12);
      default: r = rotl64(v, 6'd18);
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/xxhash64_stream_hasher.sv =====
// XXH64 (seed zero) hasher over a byte stream, one byte per item.
// Depends on xxh64_pkg.
//
//   channel | ports                                 | dir | handshake
//   --------+---------------------------------------+-----+---------------------
//   input   | in_valid in_data_byte in_last         | in  | in_stall (out)
//   result  | out_valid out_hash_value              | out | out_stall (in)
//
// A byte that does not complete a stripe leaves the sequencer idle, ready for the
// next byte, unless it is final. A byte that completes a 32-byte stripe runs,
// per lane, a word read from the stripe memory and two products on the shared
// 32x32 multiplier. A final byte then starts finalization: the lane merge
// (32 bytes or more), a fold per 8-byte tail word, for a 4-byte word and per tail
// byte. in_stall is high whenever the sequencer is not idle. The hash waits
// in an output register; out_stall holds it and blocks only the next emit.
// Reset (rst_n low, synchronous) returns the lanes and byte count to start values.
module xxhash64_stream_hasher
  import xxh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value
);

  // Sequencer
  st_t         st_r, st_nxt;
  st_t         ret_r, ret_nxt;
  kc_t         kc_r, kc_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [3:0]  rc_r, rc_nxt;
  logic [3:0]  ld_len_r, ld_len_nxt;
  logic [4:0]  ld_base_r, ld_base_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        last_r, last_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic [63:0] lane_r [4];
  logic [63:0] lane_nxt [4];
  logic        out_valid_r, out_valid_nxt;

  // Datapath payload
  logic [63:0] ma_r, ma_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] pp_r;
  logic [63:0] h_r, h_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  // Stripe memory
  logic [7:0]  stripe_mem [32];
  logic [7:0]  rd_data_r;
  logic [4:0]  rd_addr;

  // Shared multiplier
  logic [31:0] mop_a, mop_b;
  logic [63:0] mul_res;
  logic [63:0] kval;

  logic        in_acc;
  logic        out_free;
  logic [63:0] cnt_inc;
  logic [4:0]  tail_rem;
  logic [63:0] lane_sel;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_inc  = cnt_r + 64'd1;
  assign tail_rem = cnt_r[4:0] - pos_r;
  assign lane_sel = lane_r[idx_r];
  assign kval     = kconst(kc_r);
  assign rd_addr  = ld_base_r + {2'b00, rc_r[2:0]};
  assign mul_res  = 64'(mop_a) * 64'(mop_b);

  // Next state
  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (cnt_inc[4:0] == 5'd0) begin
            st_nxt = ST_ABS_LD;
          end else if (in_last) begin
            st_nxt = ST_FIN_START;
          end
        end
      end
      ST_LD:        if (rc_r == ld_len_r) st_nxt = ret_r;
      ST_MUL:       if (ph_r == 2'd3) st_nxt = ret_r;
      ST_ABS_LD:    begin st_nxt = ST_LD;  ret_nxt = ST_ABS_M1;  end
      ST_ABS_M1:    begin st_nxt = ST_MUL; ret_nxt = ST_ABS_ADD; end
      ST_ABS_ADD:   begin st_nxt = ST_MUL; ret_nxt = ST_ABS_WR;  end
      ST_ABS_WR: begin
        if (idx_r != 2'd3) begin
          st_nxt = ST_ABS_LD;
        end else if (last_r) begin
          st_nxt = ST_FIN_START;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_FIN_START: st_nxt = (|cnt_r[63:5]) ? ST_MRG_ADD : ST_ADD_LEN;
      ST_MRG_ADD:   if (idx_r == 2'd3) st_nxt = ST_MRG_M1;
      ST_MRG_M1:    begin st_nxt = ST_MUL; ret_nxt = ST_MRG_M2; end
      ST_MRG_M2:    begin st_nxt = ST_MUL; ret_nxt = ST_MRG_X;  end
      ST_MRG_X:     begin st_nxt = ST_MUL; ret_nxt = ST_MRG_P4; end
      ST_MRG_P4:    st_nxt = (idx_r == 2'd3) ? ST_ADD_LEN : ST_MRG_M1;
      ST_ADD_LEN:   st_nxt = ST_TAIL;
      ST_TAIL: begin
        if (tail_rem >= 5'd8) begin
          st_nxt = ST_LD; ret_nxt = ST_T8_M1;
        end else if (tail_rem >= 5'd4) begin
          st_nxt = ST_LD; ret_nxt = ST_T4_M1;
        end else if (tail_rem != 5'd0) begin
          st_nxt = ST_LD; ret_nxt = ST_T1_M1;
        end else begin
          st_nxt = ST_AVA0;
        end
      end
      ST_T8_M1:     begin st_nxt = ST_MUL; ret_nxt = ST_T8_M2; end
      ST_T8_M2:     begin st_nxt = ST_MUL; ret_nxt = ST_T8_X;  end
      ST_T8_X:      begin st_nxt = ST_MUL; ret_nxt = ST_T8_P4; end
      ST_T8_P4:     st_nxt = ST_TAIL;
      ST_T4_M1:     begin st_nxt = ST_MUL; ret_nxt = ST_T4_X;  end
      ST_T4_X:      begin st_nxt = ST_MUL; ret_nxt = ST_T4_P3; end
      ST_T4_P3:     st_nxt = ST_TAIL;
      ST_T1_M1:     begin st_nxt = ST_MUL; ret_nxt = ST_T1_X;  end
      ST_T1_X:      begin st_nxt = ST_MUL; ret_nxt = ST_T1_WR; end
      ST_T1_WR:     st_nxt = ST_TAIL;
      ST_AVA0:      begin st_nxt = ST_MUL; ret_nxt = ST_AVA1; end
      ST_AVA1:      begin st_nxt = ST_MUL; ret_nxt = ST_AVA2; end
      ST_AVA2:      st_nxt = ST_EMIT;
      ST_EMIT:      if (out_free) st_nxt = ST_IDLE;
      default:      st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and counters
  always_comb begin
    kc_nxt        = kc_r;
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    rc_nxt        = rc_r;
    ld_len_nxt    = ld_len_r;
    ld_base_nxt   = ld_base_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    ma_nxt        = ma_r;
    prod_nxt      = prod_r;
    h_nxt         = h_r;
    out_hash_nxt  = out_hash_r;
    // drop the result once taken
    out_valid_nxt = out_valid_r && out_stall;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_nxt  = cnt_inc;
          last_nxt = in_last;
          idx_nxt  = 2'd0;
        end
      end
      ST_LD: begin
        // shift in the byte read last cycle, little-endian
        if (rc_r != 4'd0) begin
          if (ld_len_r == LD_W64) begin
            ma_nxt = {rd_data_r, ma_r[63:8]};
          end else if (ld_len_r == LD_W32) begin
            ma_nxt = {32'd0, rd_data_r, ma_r[31:8]};
          end else begin
            ma_nxt = {56'd0, rd_data_r};
          end
        end
        rc_nxt = (rc_r == ld_len_r) ? 4'd0 : rc_r + 4'd1;
      end
      ST_MUL: begin
        // low 64 bits from three 32x32 partial products
        unique case (ph_r)
          2'd0:    prod_nxt = prod_r;
          2'd1:    prod_nxt = pp_r;
          default: prod_nxt = prod_r + {pp_r[31:0], 32'd0};
        endcase
        ph_nxt = ph_r + 2'd1;
      end
      ST_ABS_LD: begin
        ld_base_nxt = {idx_r, 3'd0};
        ld_len_nxt  = LD_W64;
        rc_nxt      = 4'd0;
      end
      ST_ABS_M1:  kc_nxt = K_P2;
      ST_ABS_ADD: begin
        ma_nxt = rotl64(lane_sel + prod_r, ROT_ROUND);
        kc_nxt = K_P1;
      end
      ST_ABS_WR: begin
        lane_nxt[idx_r] = prod_r;
        idx_nxt         = idx_r + 2'd1;
      end
      ST_FIN_START: begin
        h_nxt   = (|cnt_r[63:5]) ? 64'd0 : P5;
        idx_nxt = 2'd0;
      end
      ST_MRG_ADD: begin
        h_nxt   = h_r + merge_rot(lane_sel, idx_r);
        idx_nxt = idx_r + 2'd1;
      end
      ST_MRG_M1: begin
        ma_nxt = lane_sel;
        kc_nxt = K_P2;
      end
      ST_MRG_M2: begin
        ma_nxt = rotl64(prod_r, ROT_ROUND);
        kc_nxt = K_P1;
      end
      ST_MRG_X: begin
        ma_nxt = h_r ^ prod_r;
        kc_nxt = K_P1;
      end
      ST_MRG_P4: begin
        h_nxt   = prod_r + P4;
        idx_nxt = idx_r + 2'd1;
      end
      ST_ADD_LEN: begin
        h_nxt   = h_r + cnt_r;
        pos_nxt = 5'd0;
      end
      ST_TAIL: begin
        ld_base_nxt = pos_r;
        rc_nxt      = 4'd0;
        if (tail_rem >= 5'd8) begin
          ld_len_nxt = LD_W64;
        end else if (tail_rem >= 5'd4) begin
          ld_len_nxt = LD_W32;
        end else begin
          ld_len_nxt = LD_W8;
        end
      end
      ST_T8_M1: kc_nxt = K_P2;
      ST_T8_M2: begin
        ma_nxt = rotl64(prod_r, ROT_ROUND);
        kc_nxt = K_P1;
      end
      ST_T8_X: begin
        ma_nxt = rotl64(h_r ^ prod_r, ROT_W64);
        kc_nxt = K_P1;
      end
      ST_T8_P4: begin
        h_nxt   = prod_r + P4;
        pos_nxt = pos_r + 5'd8;
      end
      ST_T4_M1: kc_nxt = K_P1;
      ST_T4_X: begin
        ma_nxt = rotl64(h_r ^ prod_r, ROT_W32);
        kc_nxt = K_P2;
      end
      ST_T4_P3: begin
        h_nxt   = prod_r + P3;
        pos_nxt = pos_r + 5'd4;
      end
      ST_T1_M1: kc_nxt = K_P5;
      ST_T1_X: begin
        ma_nxt = rotl64(h_r ^ prod_r, ROT_W8);
        kc_nxt = K_P1;
      end
      ST_T1_WR: begin
        h_nxt   = prod_r;
        pos_nxt = pos_r + 5'd1;
      end
      ST_AVA0: begin
        ma_nxt = h_r ^ (h_r >> AVA_SH1);
        kc_nxt = K_P2;
      end
      ST_AVA1: begin
        ma_nxt = prod_r ^ (prod_r >> AVA_SH2);
        kc_nxt = K_P3;
      end
      ST_AVA2: h_nxt = prod_r ^ (prod_r >> AVA_SH3);
      ST_EMIT: begin
        // hand off the hash and restart the message
        if (out_free) begin
          out_hash_nxt  = h_r;
          out_valid_nxt = 1'b1;
          cnt_nxt       = 64'd0;
          for (int i = 0; i < 4; i++) begin
            lane_nxt[i] = lane_init(2'(i));
          end
        end
      end
      default: ;
    endcase
  end

  // Port outputs and multiplier operand select
  always_comb begin
    in_stall       = (st_r != ST_IDLE);
    out_valid      = out_valid_r;
    out_hash_value = out_hash_r;
    mop_a          = (ph_r == 2'd2) ? ma_r[63:32] : ma_r[31:0];
    mop_b          = (ph_r == 2'd1) ? kval[63:32] : kval[31:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ret_r       <= ST_IDLE;
      kc_r        <= K_P1;
      ph_r        <= 2'd0;
      idx_r       <= 2'd0;
      rc_r        <= 4'd0;
      ld_len_r    <= LD_W64;
      ld_base_r   <= 5'd0;
      pos_r       <= 5'd0;
      last_r      <= 1'b0;
      cnt_r       <= 64'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lane_r[i] <= lane_init(2'(i));
      end
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      kc_r        <= kc_nxt;
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      rc_r        <= rc_nxt;
      ld_len_r    <= ld_len_nxt;
      ld_base_r   <= ld_base_nxt;
      pos_r       <= pos_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      lane_r      <= lane_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ma_r       <= ma_nxt;
    prod_r     <= prod_nxt;
    pp_r       <= mul_res;
    h_r        <= h_nxt;
    out_hash_r <= out_hash_nxt;
  end

  // Stripe memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stripe_mem[cnt_r[4:0]] <= in_data_byte;
    end
    rd_data_r <= stripe_mem[rd_addr];
  end

endmodule

// ===== hdl/xxh64_chk.sv =====
// Port-level checker for the XXH64 stream hasher, bound to its top level.
// Depends on xxhash64_stream_hasher_assert.svh.
`include "xxhash64_stream_hasher_assert.svh"

module xxh64_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash_value
);

  // Hold a stalled result
  `XXH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `XXH_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_hash_value), "stalled hash changed")
  // Final byte starts finalization, so input stalls next cycle
  `XXH_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && in_last, in_stall, "input open after final byte")
  // A new hash leaves the block idle and open for the next message
  `XXH_ASSERT_NOW(a_emit_idle, $rose(out_valid), !in_stall, "input stalled after hash emit")

endmodule

bind xxhash64_stream_hasher xxh64_chk u_xxh64_chk (.*);

// ===== bench/tb.sv =====
// Self-checking bench for xxhash64_stream_hasher: byte messages in, XXH64 digests out.
// Depends on the hasher RTL; the digest is predicted by a local model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
  localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
  localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
  localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
  localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

  localparam int IDLE_PCT     = 24;
  localparam int STALL_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 300;
  localparam int TARGET_BYTES = 1550;

  // Byte fill patterns for a message
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MIXED} fill_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash_value;

  // Predictor state
  logic [63:0] lane_acc [4];
  logic [7:0]  stripe_mem [32];
  logic [63:0] msg_len;

  logic [63:0] digest_expect_q [$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          digests_seen = 0;
  int          quiet_cycles = 0;
  bit          idling_on = 1'b1;

  xxhash64_stream_hasher dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] rol64(input logic [63:0] v, input int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic logic [63:0] lane_mix(input logic [63:0] acc, input logic [63:0] w);
    return rol64(acc + w * PRIME2, 31) * PRIME1;
  endfunction

  // Little-endian word of nbytes from the stripe memory
  function automatic logic [63:0] stripe_word(input int pos, input int nbytes);
    logic [63:0] w;
    int i;
    w = '0;
    for (i = nbytes - 1; i >= 0; i--) w = (w << 8) | {56'd0, stripe_mem[(pos + i) & 31]};
    return w;
  endfunction

  function automatic void lanes_restart();
    lane_acc[0] = PRIME1 + PRIME2;
    lane_acc[1] = PRIME2;
    lane_acc[2] = 64'd0;
    lane_acc[3] = 64'd0 - PRIME1;
    msg_len = 64'd0;
  endfunction

  // Merge or short start, add length, fold the tail, then avalanche
  function automatic logic [63:0] digest_of_message();
    logic [63:0] h;
    int tail;
    int pos;
    int i;
    tail = int'(msg_len[4:0]);
    pos = 0;
    if (msg_len >= 64'd32) begin
      h = rol64(lane_acc[0], 1) + rol64(lane_acc[1], 7)
        + rol64(lane_acc[2], 12) + rol64(lane_acc[3], 18);
      for (i = 0; i < 4; i++) begin
        h = h ^ lane_mix(64'd0, lane_acc[i]);
        h = h * PRIME1 + PRIME4;
      end
    end else begin
      h = PRIME5;
    end
    h = h + msg_len;
    while (pos + 8 <= tail) begin
      h = h ^ lane_mix(64'd0, stripe_word(pos, 8));
      h = rol64(h, 27) * PRIME1 + PRIME4;
      pos += 8;
    end
    if (pos + 4 <= tail) begin
      h = h ^ (stripe_word(pos, 4) * PRIME1);
      h = rol64(h, 23) * PRIME2 + PRIME3;
      pos += 4;
    end
    while (pos < tail) begin
      h = h ^ ({56'd0, stripe_mem[pos]} * PRIME5);
      h = rol64(h, 11) * PRIME1;
      pos += 1;
    end
    h = h ^ (h >> 33);
    h = h * PRIME2;
    h = h ^ (h >> 29);
    h = h * PRIME3;
    h = h ^ (h >> 32);
    return h;
  endfunction

  // Advance the model by one accepted byte; queue a digest on the final byte
  function automatic void hash_accept_byte(input logic [7:0] b, input logic lst);
    int i;
    stripe_mem[msg_len[4:0]] = b;
    msg_len = msg_len + 64'd1;
    if (msg_len[4:0] == 5'd0)
      for (i = 0; i < 4; i++) lane_acc[i] = lane_mix(lane_acc[i], stripe_word(i * 8, 8));
    if (lst) begin
      digest_expect_q = {digest_expect_q, digest_of_message()};
      lanes_restart();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %016h expected %016h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Send one item, with random gaps ahead of it; hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_accept_byte(b, lst);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_byte(input fill_t fill);
    logic [7:0] b;
    case (fill)
      FILL_ZERO: b = 8'h00;
      FILL_ONES: b = 8'hFF;
      FILL_MIXED: begin
        case ($urandom_range(3))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  task automatic send_message(input int len, input fill_t fill);
    int i;
    for (i = 0; i < len; i++) send_byte(pick_byte(fill), i == len - 1);
  endtask

  // Hold the sender until every queued digest has come back
  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_expect_q.size() != 0) @(posedge clk);
  endtask

  // Single bytes at both extremes, then tails with 8-byte, 4-byte and single folds
  task automatic test_short_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_message(12, FILL_ONES);
    send_message(11, FILL_ZERO);
  endtask

  // Stripe filled exactly on the final byte (one and two stripes), one byte short of two stripes, and one byte past one
  task automatic test_stripe_boundary();
    send_message(32, FILL_RANDOM);
    send_message(64, FILL_MIXED);
    send_message(63, FILL_RANDOM);
    send_message(33, FILL_ONES);
  endtask

  // Back-to-back traffic with no gaps or stalls on either side
  task automatic test_back_to_back();
    idling_on = 1'b0;
    while (bytes_sent < 520) send_message($urandom_range(1, 45), FILL_RANDOM);
    idling_on = 1'b1;
  endtask

  // Random lengths, mostly short, a few spanning several stripes
  task automatic test_random_messages();
    int pct;
    int len;
    fill_t fill;
    while (bytes_sent < TARGET_BYTES || digests_seen + digest_expect_q.size() < 45) begin
      pct = $urandom_range(99);
      if (pct < 85)      len = $urandom_range(1, 40);
      else if (pct < 97) len = $urandom_range(41, 130);
      else               len = $urandom_range(200, 300);
      pct = $urandom_range(99);
      if (pct < 80)      fill = FILL_RANDOM;
      else if (pct < 90) fill = FILL_MIXED;
      else if (pct < 95) fill = FILL_ZERO;
      else               fill = FILL_ONES;
      send_message(len, fill);
    end
  endtask

  // Check each digest taken and randomize the receiver's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      digests_seen++;
      if (digest_expect_q.size() == 0) begin
        report_mismatch("unexpected digest", out_hash_value, 64'd0);
      end else begin
        if (out_hash_value !== digest_expect_q[0])
          report_mismatch("hash_value", out_hash_value, digest_expect_q[0]);
        void'(digest_expect_q.pop_front());
      end
    end
    out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: end the run when no item moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    lanes_restart();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_messages();
    drain_digests();
    test_stripe_boundary();
    drain_digests();
    test_back_to_back();
    test_random_messages();

    // Let the last digest out, then allow for late extras
    in_valid <= 1'b0;
    while (digest_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digest_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
